[rtl/core/mep_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event parser package
// Shared types, status byte codes and the channel voice decode function.
// ----------------------------------------------------------------------------
package mep_pkg;

  // Number of source ports that are accepted; requests from higher ports are ignored.
  localparam int unsigned SourcePorts = 128;
  // Results kept per request; later results are dropped.
  localparam int unsigned MaxResults  = 6;

  // System status bytes.
  localparam logic [7:0] StSxStart   = 8'hF0;
  localparam logic [7:0] StQframe    = 8'hF1;
  localparam logic [7:0] StSongPos   = 8'hF2;
  localparam logic [7:0] StSongSel   = 8'hF3;
  localparam logic [7:0] StTuneReq   = 8'hF6;
  localparam logic [7:0] StSxEnd     = 8'hF7;
  localparam logic [7:0] StRtLo      = 8'hF8;
  localparam logic [7:0] StRtHi      = 8'hFC;
  localparam logic [7:0] StActSense  = 8'hFE;
  localparam logic [3:0] NibSystem   = 4'hF;

  typedef enum logic [3:0] {
    K_NOTE_OFF   = 4'd0,
    K_NOTE_ON    = 4'd1,
    K_POLY_TOUCH = 4'd2,
    K_CONTROL    = 4'd3,
    K_PROGRAM    = 4'd4,
    K_TOUCH      = 4'd5,
    K_BEND       = 4'd6,
    K_QFRAME     = 4'd7,
    K_SONG_POS   = 4'd8,
    K_SONG_SEL   = 4'd9,
    K_REALTIME   = 4'd10,
    K_SX_BYTE    = 4'd11,
    K_SX_OK      = 4'd12,
    K_SX_BAD     = 4'd13
  } kind_e;

  // Classification made by the front end.
  typedef enum logic [1:0] {
    CLS_VOICE = 2'd0,
    CLS_SCAN  = 2'd1,
    CLS_DATA  = 2'd2,
    CLS_DROP  = 2'd3
  } cls_e;

  typedef struct packed {
    logic [6:0]      port;
    logic [3:0][7:0] bytes;   // bytes[0] is the first byte of the word
    cls_e            cls;
  } item_t;

  typedef struct packed {
    logic [6:0]  port_tag;
    kind_e       kind;
    logic [3:0]  channel;
    logic [13:0] value_a;
    logic [7:0]  value_b;
    logic [7:0]  sysex_byte;
    logic        last;
  } res_t;

  // Builds a channel voice result from the status nibble, channel and data bytes.
  function automatic res_t make_voice(logic [6:0] port, logic [7:0] status,
                                      logic [7:0] d1, logic [7:0] d2);
    res_t r;
    r            = '0;
    r.port_tag   = port;
    r.kind       = kind_e'({1'b0, status[6:4]});
    r.channel    = status[3:0];
    if (status[6:4] == 3'd6) begin
      r.value_a = {d2[6:0], d1[6:0]};
    end else begin
      r.value_a = {6'b0, d1};
    end
    if (!status[6]) begin
      r.value_b = d2;
    end
    return r;
  endfunction

endpackage

[rtl/core/mep_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event parser front end
// Classifies incoming event words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mep_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [6:0]     source_port_i,
  input  logic [7:0]     byte_zero_i,
  input  logic [7:0]     byte_one_i,
  input  logic [7:0]     byte_two_i,
  input  logic [7:0]     byte_three_i,
  input  logic           deq_i,
  output logic           head_valid_o,
  output mep_pkg::item_t head_o
);
  import mep_pkg::*;

  item_t       mem_q [2];
  item_t       item_in;
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        do_push;

  // Classify the incoming word.
  always_comb begin
    item_in.port  = source_port_i;
    item_in.bytes = {byte_three_i, byte_two_i, byte_one_i, byte_zero_i};
    if ({2'b0, source_port_i} >= 9'(SourcePorts)) begin
      item_in.cls = CLS_DROP;
    end else if (!byte_zero_i[7]) begin
      item_in.cls = CLS_DATA;
    end else if (byte_zero_i[7:4] == NibSystem) begin
      item_in.cls = CLS_SCAN;
    end else begin
      item_in.cls = CLS_VOICE;
    end
  end

  // Queue pointers and fill count.
  assign full         = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (deq_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !deq_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && deq_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

[rtl/core/mep_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event parser back end
// Steps through one event word, keeps running status and the sysex flag.
// ----------------------------------------------------------------------------
module mep_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           head_valid_i,
  input  mep_pkg::item_t head_i,
  output logic           deq_o,
  input  logic           out_full_i,
  output logic           res_push_o,
  output mep_pkg::res_t  res_o
);
  import mep_pkg::*;

  logic [7:0] rs_q, rs_d;
  logic       sx_q, sx_d;
  logic [1:0] pos_q, pos_d;
  logic       ph_q, ph_d;
  logic       fl_q, fl_d;
  logic [2:0] cnt_q, cnt_d;
  logic       pv_q, pv_d;
  res_t       pend_q, pend_d;

  logic       step, flush, do_scan, adv, done, gen_v;
  res_t       gen;
  logic [7:0] c, n1, n2;

  assign step  = head_valid_i && !fl_q && !out_full_i;
  assign flush = head_valid_i && fl_q && !out_full_i;

  // Bytes seen at the current scan position; bytes past the word read as zero.
  always_comb begin
    c  = head_i.bytes[pos_q];
    n1 = (pos_q == 2'd3) ? 8'h00 : head_i.bytes[pos_q + 2'd1];
    n2 = pos_q[1] ? 8'h00 : head_i.bytes[pos_q + 2'd2];
  end

  // One step of decode: at most one result per cycle.
  always_comb begin
    rs_d        = rs_q;
    sx_d        = sx_q;
    ph_d        = ph_q;
    do_scan     = 1'b0;
    adv         = 1'b0;
    done        = 1'b0;
    gen_v       = 1'b0;
    gen         = '0;
    gen.port_tag = head_i.port;
    if (step) begin
      unique case (head_i.cls)
        CLS_DROP: begin
          done = 1'b1;
        end
        CLS_VOICE: begin
          rs_d  = head_i.bytes[0];
          gen   = make_voice(head_i.port, head_i.bytes[0], head_i.bytes[1],
                             head_i.bytes[2]);
          gen_v = 1'b1;
          done  = 1'b1;
        end
        CLS_DATA: begin
          if (sx_q) begin
            do_scan = 1'b1;
          end else begin
            if (rs_q != 8'h00) begin
              gen   = make_voice(head_i.port, rs_q, head_i.bytes[0], head_i.bytes[1]);
              gen_v = 1'b1;
            end
            done = 1'b1;
          end
        end
        CLS_SCAN: begin
          if (pos_q == 2'd0 && !ph_q) begin
            rs_d = 8'h00;
          end
          do_scan = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase

      // Byte scan over system codes and sysex content.
      if (do_scan) begin
        case (c) inside
          StSxStart: begin
            gen_v = 1'b1;
            if (!ph_q && sx_q) begin
              gen.kind = K_SX_BAD;
              sx_d     = 1'b0;
              ph_d     = 1'b1;
            end else begin
              rs_d           = 8'h00;
              sx_d           = 1'b1;
              gen.kind       = K_SX_BYTE;
              gen.sysex_byte = c;
              ph_d           = 1'b0;
              adv            = 1'b1;
            end
          end
          StSxEnd: begin
            gen_v = 1'b1;
            if (!ph_q) begin
              gen.kind       = K_SX_BYTE;
              gen.sysex_byte = c;
              ph_d           = 1'b1;
            end else begin
              gen.kind = sx_q ? K_SX_OK : K_SX_BAD;
              sx_d     = 1'b0;
              done     = 1'b1;
            end
          end
          StQframe: begin
            gen_v       = 1'b1;
            gen.kind    = K_QFRAME;
            gen.value_a = {10'b0, n1[7:4]};
            gen.value_b = n1[4] ? {n1[3:0], 4'b0} : {4'b0, n1[3:0]};
            done        = 1'b1;
          end
          StSongPos: begin
            gen_v       = 1'b1;
            gen.kind    = K_SONG_POS;
            gen.value_a = {n2[6:0], n1[6:0]};
            done        = 1'b1;
          end
          StSongSel: begin
            gen_v       = 1'b1;
            gen.kind    = K_SONG_SEL;
            gen.value_a = {6'b0, n1};
            done        = 1'b1;
          end
          StTuneReq, [StRtLo:StRtHi], StActSense: begin
            rs_d        = 8'h00;
            gen_v       = 1'b1;
            gen.kind    = K_REALTIME;
            gen.value_a = {10'b0, c[3:0]};
            adv         = 1'b1;
          end
          default: begin
            if (c[7]) begin
              // A stray status byte ends the sysex as invalid.
              gen_v = 1'b1;
              if (!ph_q) begin
                gen.kind       = K_SX_BYTE;
                gen.sysex_byte = c;
                ph_d           = 1'b1;
              end else begin
                gen.kind = K_SX_BAD;
                sx_d     = 1'b0;
                done     = 1'b1;
              end
            end else begin
              if (sx_q) begin
                gen_v          = 1'b1;
                gen.kind       = K_SX_BYTE;
                gen.sysex_byte = c;
              end
              adv = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Position, pending result and output pushes.
  always_comb begin
    pos_d      = pos_q;
    fl_d       = fl_q;
    cnt_d      = cnt_q;
    pv_d       = pv_q;
    pend_d     = pend_q;
    res_push_o = 1'b0;
    res_o      = pend_q;
    res_o.last = 1'b0;
    deq_o      = 1'b0;
    if (step) begin
      if (gen_v && (cnt_q < 3'(MaxResults))) begin
        res_push_o = pv_q;
        pend_d     = gen;
        pv_d       = 1'b1;
        cnt_d      = cnt_q + 3'd1;
      end
      if (adv) begin
        if (pos_q == 2'd3) begin
          fl_d = 1'b1;
        end else begin
          pos_d = pos_q + 2'd1;
        end
      end
      if (done) begin
        fl_d = 1'b1;
      end
    end
    if (flush) begin
      // The last kept result of the word goes out marked as final.
      res_push_o = pv_q;
      res_o.last = 1'b1;
      deq_o      = 1'b1;
      fl_d       = 1'b0;
      pos_d      = 2'd0;
      pv_d       = 1'b0;
      cnt_d      = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q  <= 8'h00;
      sx_q  <= 1'b0;
      pos_q <= 2'd0;
      ph_q  <= 1'b0;
      fl_q  <= 1'b0;
      cnt_q <= 3'd0;
      pv_q  <= 1'b0;
    end else begin
      rs_q  <= rs_d;
      sx_q  <= sx_d;
      pos_q <= pos_d;
      ph_q  <= (step && (adv || done)) ? 1'b0 : ph_d;
      fl_q  <= fl_d;
      cnt_q <= cnt_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

[rtl/core/mep_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI event parser result queue
// Two-entry queue that parts the back end from the result consumer.
// ----------------------------------------------------------------------------
module mep_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mep_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop,
  output logic          empty,
  output mep_pkg::res_t res_o
);
  import mep_pkg::*;

  res_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty   = (cnt_q == 2'd0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;

  // Fill count.
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

[rtl/core/midi_event_parser_top.sv]
`timescale 1ns / 1ps
// Sequencing: the back end decodes a channel voice or running status word and then closes it;
// a scanned word gets a step per byte, an extra step for a byte with two results, and a closing step.
// The back end's byte sequencer sets the pace and stalls while the result queue is full;
// a two-entry queue on each side lets input and output stall independently.
// Reset: asynchronous, active low; clears both queues, running status and sysex flag.
// ----------------------------------------------------------------------------
// MIDI event parser top level
// Parses four-byte MIDI event words into decoded events and sysex bytes.
// ----------------------------------------------------------------------------
module midi_event_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [6:0]  source_port_i,
  input  logic [7:0]  byte_zero_i,
  input  logic [7:0]  byte_one_i,
  input  logic [7:0]  byte_two_i,
  input  logic [7:0]  byte_three_i,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  port_tag_o,
  output logic [3:0]  event_kind_o,
  output logic [3:0]  channel_o,
  output logic [13:0] value_a_o,
  output logic [7:0]  value_b_o,
  output logic [7:0]  sysex_byte_o,
  output logic        last_o
);
  import mep_pkg::*;

  item_t head;
  logic  head_valid;
  logic  deq;
  logic  res_push;
  logic  outq_full;
  res_t  res;
  res_t  res_out;

  // Front end: classification and input queue.
  mep_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .source_port_i (source_port_i),
    .byte_zero_i   (byte_zero_i),
    .byte_one_i    (byte_one_i),
    .byte_two_i    (byte_two_i),
    .byte_three_i  (byte_three_i),
    .deq_i         (deq),
    .head_valid_o  (head_valid),
    .head_o        (head)
  );

  // Back end: byte sequencer with parser state.
  mep_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .deq_o        (deq),
    .out_full_i   (outq_full),
    .res_push_o   (res_push),
    .res_o        (res)
  );

  // Result queue.
  mep_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res),
    .full_o (outq_full),
    .pop    (pop),
    .empty  (empty),
    .res_o  (res_out)
  );

  assign port_tag_o   = res_out.port_tag;
  assign event_kind_o = res_out.kind;
  assign channel_o    = res_out.channel;
  assign value_a_o    = res_out.value_a;
  assign value_b_o    = res_out.value_b;
  assign sysex_byte_o = res_out.sysex_byte;
  assign last_o       = res_out.last;

`ifndef SYNTHESIS
  // The back end never pushes into a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !outq_full)
    else $error("result pushed into full queue");

  // A word leaves the front queue only when one is there.
  assert property (@(posedge clk_i) disable iff (!rst_ni) deq |-> head_valid)
    else $error("dequeue from empty front queue");

  // The final result of a word is pushed exactly when the word is retired.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> (res.last == deq))
    else $error("last flag out of step with word retirement");
`endif

endmodule
